### hw/rtl/sspq_pkg.sv
package sspq_pkg;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

### hw/rtl/sspq_if.sv
interface sspq_in_if #(
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 9
);
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [KEY_WIDTH-1:0]    item_key;
    logic [HANDLE_WIDTH-1:0] item_handle;

    modport source (output valid, mode, item_key, item_handle, input ready);
    modport sink   (input valid, mode, item_key, item_handle, output ready);
endinterface

interface sspq_out_if #(
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 9,
    parameter int OCC_WIDTH    = 7
);
    logic                    valid;
    logic                    ready;
    logic                    out_valid;
    logic [KEY_WIDTH-1:0]    out_key;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic                    was_empty;
    logic                    overflow;
    logic [OCC_WIDTH-1:0]    occupancy;

    modport source (output valid, out_valid, out_key, out_handle, was_empty, overflow,
                    occupancy, input ready);
    modport sink   (input valid, out_valid, out_key, out_handle, was_empty, overflow,
                    occupancy, output ready);
endinterface

### hw/rtl/sspq_cell.sv
module sspq_cell #(
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 9,
    parameter int CNT_W        = 7,
    parameter int INDEX        = 0
) (
    input  logic                    i_clk,
    input  sspq_pkg::t_cell_ctl     i_ctl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [KEY_WIDTH-1:0]    i_new_key,
    input  logic [HANDLE_WIDTH-1:0] i_new_handle,
    input  logic                    i_prev_after,
    input  logic [KEY_WIDTH-1:0]    i_prev_key,
    input  logic [HANDLE_WIDTH-1:0] i_prev_handle,
    input  logic [KEY_WIDTH-1:0]    i_next_key,
    input  logic [HANDLE_WIDTH-1:0] i_next_handle,
    output logic                    o_after,
    output logic [KEY_WIDTH-1:0]    o_key,
    output logic [HANDLE_WIDTH-1:0] o_handle
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [KEY_WIDTH-1:0]    r_key;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [KEY_WIDTH-1:0]    n_key;
    logic [HANDLE_WIDTH-1:0] n_handle;
    logic                    occupied;

    // new pair goes at or before this slot: slot empty or holds a larger key
    assign occupied = i_count > IDX;
    assign o_after  = !occupied || (r_key > i_new_key);

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.insert) begin
            if (i_prev_after) begin
                n_key    = i_prev_key;
                n_handle = i_prev_handle;
            end else if (o_after) begin
                n_key    = i_new_key;
                n_handle = i_new_handle;
            end
        end else if (i_ctl.remove) begin
            n_key    = i_next_key;
            n_handle = i_next_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule

### hw/rtl/stable_sorted_priority_queue.sv
// Sorted shift-register queue: a row of DEPTH compare-and-shift cells.
// Throughput: one item per cycle while the receiver takes results; each item gives one result item.
// The result is registered and shows in the cycle after the item is accepted.
// The new key is broadcast to all cells; each cell compares and shifts in the same cycle.
// Reset (synchronous, active low) empties the queue and clears the output valid.
module stable_sorted_priority_queue #(
    parameter int DEPTH        = 64,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspq_in_if.sink     i_in,
    sspq_out_if.source  o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_vld;
    logic                    r_res_valid;
    logic [KEY_WIDTH-1:0]    r_res_key;
    logic [HANDLE_WIDTH-1:0] r_res_handle;
    logic                    r_res_empty;
    logic                    r_res_ovf;

    logic                    accept;
    logic                    is_remove;
    logic                    full;
    logic                    empty;
    sspq_pkg::t_cell_ctl     ctl;

    logic [KEY_WIDTH-1:0]    cell_key    [DEPTH];
    logic [HANDLE_WIDTH-1:0] cell_handle [DEPTH];
    logic                    cell_after  [DEPTH];

    assign i_in.ready = !r_out_vld || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_remove  = (i_in.mode == sspq_pkg::MODE_REMOVE);
    assign full       = (r_count == FULL_CNT);
    assign empty      = (r_count == '0);

    assign ctl.insert = accept && !is_remove && !full;
    assign ctl.remove = accept && is_remove && !empty;

    always_comb begin
        n_count = r_count;
        if (ctl.insert) begin
            n_count = r_count + 1'b1;
        end else if (ctl.remove) begin
            n_count = r_count - 1'b1;
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic                    prev_after;
            logic [KEY_WIDTH-1:0]    prev_key;
            logic [HANDLE_WIDTH-1:0] prev_handle;
            logic [KEY_WIDTH-1:0]    next_key;
            logic [HANDLE_WIDTH-1:0] next_handle;

            if (g == 0) begin : g_first
                assign prev_after  = 1'b0;
                assign prev_key    = '0;
                assign prev_handle = '0;
            end else begin : g_mid_prev
                assign prev_after  = cell_after[g-1];
                assign prev_key    = cell_key[g-1];
                assign prev_handle = cell_handle[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_key    = '0;
                assign next_handle = '0;
            end else begin : g_mid_next
                assign next_key    = cell_key[g+1];
                assign next_handle = cell_handle[g+1];
            end

            sspq_cell #(
                .KEY_WIDTH    (KEY_WIDTH),
                .HANDLE_WIDTH (HANDLE_WIDTH),
                .CNT_W        (CNT_W),
                .INDEX        (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_count       (r_count),
                .i_new_key     (i_in.item_key),
                .i_new_handle  (i_in.item_handle),
                .i_prev_after  (prev_after),
                .i_prev_key    (prev_key),
                .i_prev_handle (prev_handle),
                .i_next_key    (next_key),
                .i_next_handle (next_handle),
                .o_after       (cell_after[g]),
                .o_key         (cell_key[g]),
                .o_handle      (cell_handle[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_valid  <= ctl.remove;
            r_res_key    <= ctl.remove ? cell_key[0] : '0;
            r_res_handle <= ctl.remove ? cell_handle[0] : '0;
            r_res_empty  <= is_remove && empty;
            r_res_ovf    <= !is_remove && full;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_valid  = r_res_valid;
    assign o_out.out_key    = r_res_key;
    assign o_out.out_handle = r_res_handle;
    assign o_out.was_empty  = r_res_empty;
    assign o_out.overflow   = r_res_ovf;
    assign o_out.occupancy  = r_count;

endmodule

### tb/sspq_checker.sv
module sspq_checker #(
    parameter int DEPTH        = 64,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 9,
    parameter int OCC_WIDTH    = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sspq_in_if   i_in_mon,
    sspq_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_returned,
    output int   o_empty_hits,
    output int   o_overflow_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]    key;
        logic [HANDLE_WIDTH-1:0] handle;
    } t_pair;

    typedef struct packed {
        logic                    out_valid;
        logic [KEY_WIDTH-1:0]    out_key;
        logic [HANDLE_WIDTH-1:0] out_handle;
        logic                    was_empty;
        logic                    overflow;
        logic [OCC_WIDTH-1:0]    occupancy;
    } t_result;

    t_pair   held_pairs[$];
    t_result awaited_results[$];

    function automatic t_result apply_queue_op(input sspq_pkg::t_mode op,
                                               input logic [KEY_WIDTH-1:0] key,
                                               input logic [HANDLE_WIDTH-1:0] handle);
        t_result r;
        t_pair   p;
        int      pos;
        r = '0;
        if (op == sspq_pkg::MODE_INSERT) begin
            if (held_pairs.size() >= DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                // stable: goes behind every pair with an equal or smaller key
                pos = 0;
                while (pos < held_pairs.size() && held_pairs[pos].key <= key)
                    pos++;
                p.key    = key;
                p.handle = handle;
                held_pairs.insert(pos, p);
            end
        end else if (held_pairs.size() == 0) begin
            r.was_empty = 1'b1;
        end else begin
            p            = held_pairs.pop_front();
            r.out_valid  = 1'b1;
            r.out_key    = p.key;
            r.out_handle = p.handle;
        end
        r.occupancy = OCC_WIDTH'(held_pairs.size());
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held_pairs.delete();
            awaited_results.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                awaited_results.push_back(apply_queue_op(sspq_pkg::t_mode'(i_in_mon.mode),
                                                         i_in_mon.item_key,
                                                         i_in_mon.item_handle));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with no pending input: key %0h handle %0h occ %0d",
                           i_out_mon.out_key, i_out_mon.out_handle, i_out_mon.occupancy);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_valid", 32'(want.out_valid), 32'(i_out_mon.out_valid));
                    check_field("out_key", 32'(want.out_key), 32'(i_out_mon.out_key));
                    check_field("out_handle", 32'(want.out_handle),
                                32'(i_out_mon.out_handle));
                    check_field("was_empty", 32'(want.was_empty), 32'(i_out_mon.was_empty));
                    check_field("overflow", 32'(want.overflow), 32'(i_out_mon.overflow));
                    check_field("occupancy", 32'(want.occupancy), 32'(i_out_mon.occupancy));
                    if (want.out_valid)
                        o_returned++;
                    if (want.was_empty)
                        o_empty_hits++;
                    if (want.overflow)
                        o_overflow_hits++;
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

### tb/stable_sorted_priority_queue_tb.sv
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 1400;
    localparam int QUIET_ITEMS     = 200;
    localparam int PRESSURE_AT     = 500;
    localparam int PRESSURE_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int issued;
    int fail_count, pending, returned, empty_hits, overflow_hits;
    bit quiet_phase;
    bit pressure_on;
    bit pressure_done;

    sspq_in_if  in_ch ();
    sspq_out_if out_ch ();

    stable_sorted_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sspq_checker pair_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_returned      (returned),
        .o_empty_hits    (empty_hits),
        .o_overflow_hits (overflow_hits)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #TIMEOUT_NS;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: short random stalls, one long hold-off on request
    initial begin
        int stall_left;
        bit long_hold;
        stall_left = 0;
        long_hold  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0 && long_hold) begin
                    long_hold     = 1'b0;
                    pressure_done = 1'b1;
                end
            end else if (pressure_on && !pressure_done && !long_hold) begin
                long_hold  = 1'b1;
                stall_left = PRESSURE_CYCLES;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            out_ch.ready <= (stall_left == 0);
        end
    end

    function automatic logic [15:0] pick_key(input int style);
        case (style)
            0, 1, 2, 3: return 16'($urandom_range(0, 7));
            4:          return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default:    return 16'($urandom());
        endcase
    endfunction

    task automatic send_item(input sspq_pkg::t_mode op, input logic [15:0] key,
                             input logic [8:0] handle);
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= op;
        in_ch.item_key    <= key;
        in_ch.item_handle <= handle;
        do @(posedge i_clk); while (!in_ch.ready);
        issued++;
    endtask

    task automatic sender_idle(input int gap_pct);
        if (!quiet_phase && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin
        int              phase_len;
        int              insert_pct;
        int              gap_pct;
        sspq_pkg::t_mode op;

        issued        = 0;
        quiet_phase   = 1'b0;
        pressure_on   = 1'b0;
        pressure_done = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= sspq_pkg::MODE_INSERT;
        in_ch.item_key    <= '0;
        in_ch.item_handle <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, key extremes, ties in arrival order, drain past empty
        send_item(sspq_pkg::MODE_REMOVE, 16'h1234, 9'h1FF);
        send_item(sspq_pkg::MODE_INSERT, 16'hFFFF, 9'h1FF);
        send_item(sspq_pkg::MODE_INSERT, 16'h0000, 9'h000);
        send_item(sspq_pkg::MODE_INSERT, 16'h8000, 9'h155);
        send_item(sspq_pkg::MODE_INSERT, 16'h8000, 9'h0AA);
        sender_idle(100);
        send_item(sspq_pkg::MODE_INSERT, 16'h8000, 9'h1FF);
        send_item(sspq_pkg::MODE_INSERT, 16'h0000, 9'h1FF);
        send_item(sspq_pkg::MODE_INSERT, 16'hFFFF, 9'h000);
        send_item(sspq_pkg::MODE_INSERT, 16'h7FFF, 9'h100);
        repeat (9) begin
            send_item(sspq_pkg::MODE_REMOVE, 16'($urandom()), 9'($urandom()));
            sender_idle(30);
        end
        send_item(sspq_pkg::MODE_INSERT, 16'h5555, 9'h0F0);
        send_item(sspq_pkg::MODE_REMOVE, 16'h0000, 9'h000);
        send_item(sspq_pkg::MODE_INSERT, 16'hAAAA, 9'h10F);
        send_item(sspq_pkg::MODE_REMOVE, 16'hFFFF, 9'h1FF);

        while (issued < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0:       insert_pct = 85;
                1:       insert_pct = 20;
                2:       insert_pct = 50;
                default: insert_pct = 62;
            endcase
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            repeat (phase_len) begin
                if (issued >= RANDOM_ITEMS - QUIET_ITEMS)
                    quiet_phase = 1'b1;
                op = ($urandom_range(0, 99) < insert_pct) ? sspq_pkg::MODE_INSERT
                                                           : sspq_pkg::MODE_REMOVE;
                send_item(op, pick_key($urandom_range(0, 9)), 9'($urandom()));
                sender_idle(gap_pct);
            end
            if (!pressure_on && issued >= PRESSURE_AT) begin
                pressure_on = 1'b1;
                while (!pressure_done)
                    send_item(sspq_pkg::MODE_INSERT, pick_key($urandom_range(0, 9)),
                              9'($urandom()));
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items: %0d pairs removed, %0d removes from an empty queue,",
                 issued, returned, empty_hits);
        $display("%0d inserts dropped on a full queue, one %0d-cycle output hold-off",
                 overflow_hits, PRESSURE_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
